/* sv/rvp_pkg.sv */
// Package with shared types and constants of the RGB565 video packetizer.
`timescale 1ns / 1ps

package rvp_pkg;

    // Configuration register widths and reset values
    localparam int PIX_CFG_W = 11;
    localparam int PKT_CFG_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam logic [PIX_CFG_W-1:0] PIX_RESET = 11'd720;
    localparam logic [PKT_CFG_W-1:0] PKT_RESET = 16'd1280;
    localparam logic [PIX_CFG_W-1:0] PIX_MAX = 11'd1024;

    // Pixel counter width within a packet
    localparam int PIX_CNT_W = 10;

    // Header sequence field is always 16 bits on the wire
    localparam int HDR_BITS = 16;

    // Configuration register indexes
    localparam logic CFG_PIXELS_PER_PACKET = 1'b0;
    localparam logic CFG_PACKETS_PER_FRAME = 1'b1;

    // Byte positions within one pixel request
    localparam logic [1:0] POS_SEQ_HI = 2'd0;
    localparam logic [1:0] POS_SEQ_LO = 2'd1;
    localparam logic [1:0] POS_PIX_HI = 2'd2;
    localparam logic [1:0] POS_PIX_LO = 2'd3;

    // Command queue depth
    localparam int CMD_DEPTH = 4;
    localparam int CMD_IDX_W = $clog2(CMD_DEPTH);

    // One classified pixel, as passed from front to back
    typedef struct packed {
        logic [HDR_BITS-1:0] seq;
        logic [7:0]          pix_hi;
        logic [7:0]          pix_lo;
        logic                hdr;
        logic                end_pkt;
        logic                end_frame;
    } cmd_t;

    // Queue status seen by the back end
    typedef struct packed {
        cmd_t cmd;
        logic empty;
    } cmd_head_t;

endpackage

/* sv/rvp_front.sv */
// Front end: configuration registers, packet counters and pixel classification.
`timescale 1ns / 1ps

module rvp_front #(
    parameter int SEQ_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [rvp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          push,
    input  logic                          full,
    input  logic [7:0]                    blue,
    input  logic [7:0]                    green,
    input  logic [7:0]                    red,
    output logic                          cmd_we,
    output rvp_pkg::cmd_t                 cmd
);

    localparam int CMP_W = rvp_pkg::PKT_CFG_W + 1;

    logic [rvp_pkg::PIX_CFG_W-1:0] pixels_per_packet_reg;
    logic [rvp_pkg::PKT_CFG_W-1:0] packets_per_frame_reg;
    logic [rvp_pkg::PIX_CNT_W-1:0] pixel_count_reg;
    logic [rvp_pkg::PIX_CNT_W-1:0] pixel_count_next;
    logic [SEQ_BITS-1:0]           packet_seq_reg;
    logic [SEQ_BITS-1:0]           packet_seq_next;

    logic [rvp_pkg::PIX_CFG_W-1:0] pix_len;
    logic [rvp_pkg::PIX_CFG_W-1:0] pix_inc;
    logic [rvp_pkg::PKT_CFG_W-1:0] frame_len;
    logic [CMP_W-1:0]              seq_inc;
    logic                          end_pkt;
    logic                          end_frame;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_per_packet_reg <= rvp_pkg::PIX_RESET;
            packets_per_frame_reg <= rvp_pkg::PKT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rvp_pkg::CFG_PIXELS_PER_PACKET:
                    pixels_per_packet_reg <= cfg_data[rvp_pkg::PIX_CFG_W-1:0];
                rvp_pkg::CFG_PACKETS_PER_FRAME:
                    packets_per_frame_reg <= cfg_data[rvp_pkg::PKT_CFG_W-1:0];
                default:
                    pixels_per_packet_reg <= pixels_per_packet_reg;
            endcase
        end
    end

    // Clamp packet and frame lengths into their legal ranges
    always_comb
    begin
        if (pixels_per_packet_reg == '0)
            pix_len = rvp_pkg::PIX_CFG_W'(1);
        else if (pixels_per_packet_reg > rvp_pkg::PIX_MAX)
            pix_len = rvp_pkg::PIX_MAX;
        else
            pix_len = pixels_per_packet_reg;

        if (packets_per_frame_reg == '0)
            frame_len = rvp_pkg::PKT_CFG_W'(1);
        else
            frame_len = packets_per_frame_reg;
    end

    // Classify the pixel: packet end, frame end, header needed
    always_comb
    begin
        pix_inc   = rvp_pkg::PIX_CFG_W'(pixel_count_reg) + rvp_pkg::PIX_CFG_W'(1);
        seq_inc   = CMP_W'(packet_seq_reg) + CMP_W'(1);
        end_pkt   = (pix_inc >= pix_len);
        // a frame longer than the counter wraps when the counter is all ones
        end_frame = end_pkt && ((seq_inc >= CMP_W'(frame_len)) || (&packet_seq_reg));

        if (end_pkt)
        begin
            pixel_count_next = '0;
            packet_seq_next  = end_frame ? '0 : SEQ_BITS'(seq_inc);
        end
        else
        begin
            pixel_count_next = pix_inc[rvp_pkg::PIX_CNT_W-1:0];
            packet_seq_next  = packet_seq_reg;
        end
    end

    // Build the request for the back end
    always_comb
    begin
        cmd_we        = push && !full;
        cmd.seq       = rvp_pkg::HDR_BITS'(packet_seq_reg);
        cmd.pix_hi    = {red[7:3], green[7:5]};
        cmd.pix_lo    = {green[4:2], blue[7:3]};
        cmd.hdr       = (pixel_count_reg == '0);
        cmd.end_pkt   = end_pkt;
        cmd.end_frame = end_frame;
    end

    // Advance counters on each accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= '0;
            packet_seq_reg  <= '0;
        end
        else if (cmd_we)
        begin
            pixel_count_reg <= pixel_count_next;
            packet_seq_reg  <= packet_seq_next;
        end
    end

endmodule

/* sv/rvp_cmd_fifo.sv */
// Short request queue between front and back ends.
`timescale 1ns / 1ps

module rvp_cmd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  rvp_pkg::cmd_t      wr_cmd,
    input  logic               rd_en,
    output logic               full,
    output rvp_pkg::cmd_head_t head
);

    localparam int CNT_W = $clog2(rvp_pkg::CMD_DEPTH + 1);

    rvp_pkg::cmd_t                 mem_reg [rvp_pkg::CMD_DEPTH];
    logic [rvp_pkg::CMD_IDX_W-1:0] wptr_reg;
    logic [rvp_pkg::CMD_IDX_W-1:0] rptr_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          do_rd;

    // Status
    assign full       = (count_reg == CNT_W'(rvp_pkg::CMD_DEPTH));
    assign head.empty = (count_reg == '0);
    assign head.cmd   = mem_reg[rptr_reg];
    assign do_rd      = rd_en && !head.empty;

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (!wr_en && do_rd)
            count_next = count_reg - CNT_W'(1);
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
                wptr_reg <= wptr_reg + rvp_pkg::CMD_IDX_W'(1);
            if (do_rd)
                rptr_reg <= rptr_reg + rvp_pkg::CMD_IDX_W'(1);
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wptr_reg] <= wr_cmd;
    end

endmodule

/* sv/rvp_back.sv */
// Back end: serialize each request into header and pixel bytes.
`timescale 1ns / 1ps

module rvp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rvp_pkg::cmd_head_t head,
    output logic               rd_en,
    input  logic               pop,
    output logic               empty,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               packet_first,
    output logic               packet_last,
    output logic               frame_last
);

    logic [1:0] idx_reg;
    logic [1:0] pos;
    logic       out_valid_reg;
    logic       advance;
    logic       last_pos;
    logic [7:0] byte_next;
    logic [7:0] byte_reg;
    logic       run_last_reg;
    logic       packet_first_reg;
    logic       packet_last_reg;
    logic       frame_last_reg;

    // Pick the byte position; requests without header start at the pixel bytes
    always_comb
    begin
        pos      = head.cmd.hdr ? idx_reg : (idx_reg + rvp_pkg::POS_PIX_HI);
        last_pos = (pos == rvp_pkg::POS_PIX_LO);
        advance  = !head.empty && (!out_valid_reg || pop);
        rd_en    = advance && last_pos;
        case (pos)
            rvp_pkg::POS_SEQ_HI: byte_next = head.cmd.seq[15:8];
            rvp_pkg::POS_SEQ_LO: byte_next = head.cmd.seq[7:0];
            rvp_pkg::POS_PIX_HI: byte_next = head.cmd.pix_hi;
            default:             byte_next = head.cmd.pix_lo;
        endcase
    end

    // Hold the output byte until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= last_pos ? 2'd0 : (idx_reg + 2'd1);
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // Load byte payload and flags
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg         <= byte_next;
            run_last_reg     <= last_pos;
            packet_first_reg <= (pos == rvp_pkg::POS_SEQ_HI);
            packet_last_reg  <= last_pos && head.cmd.end_pkt;
            frame_last_reg   <= last_pos && head.cmd.end_frame;
        end
    end

    assign empty        = !out_valid_reg;
    assign out_byte     = byte_reg;
    assign run_last     = run_last_reg;
    assign packet_first = packet_first_reg;
    assign packet_last  = packet_last_reg;
    assign frame_last   = frame_last_reg;

endmodule

/* sv/rgb565_video_packetizer.sv */
// Top level of the RGB565 video packetizer.
//
// Pixels enter through a queue-like port: present blue, green and red with
// push; the pixel is taken on a clock edge where push is high and full low.
// Bytes leave through a second queue-like port: while empty is low, out_byte
// and its flags show the oldest byte, and pop takes it.
// Each pixel yields two RGB565 bytes; the first pixel of a packet yields the
// two header bytes of the 16-bit sequence number first, so four bytes.
// The output byte register sends one byte per cycle while the receiver pops
// each byte; a pixel's first byte passes through the request queue and then
// the output byte register. A four-entry request queue lets pushes continue
// while the receiver stalls; full rises when it fills.
// Configuration (pixels_per_packet at index 0, packets_per_frame at index 1)
// is written with cfg_we. Reset clears counters, queue and output, and loads
// 720 pixels per packet and 1280 packets per frame.
`timescale 1ns / 1ps

module rgb565_video_packetizer #(
    parameter int SEQ_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [rvp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     blue,
    input  logic [7:0]                     green,
    input  logic [7:0]                     red,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     out_byte,
    output logic                           run_last,
    output logic                           packet_first,
    output logic                           packet_last,
    output logic                           frame_last
);

    logic               cmd_we;
    rvp_pkg::cmd_t      cmd;
    logic               cmd_rd;
    rvp_pkg::cmd_head_t head;

    // Accept and classify pixels
    rvp_front #(
        .SEQ_BITS(SEQ_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push),
        .full     (full),
        .blue     (blue),
        .green    (green),
        .red      (red),
        .cmd_we   (cmd_we),
        .cmd      (cmd)
    );

    // Queue requests
    rvp_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cmd_we),
        .wr_cmd(cmd),
        .rd_en (cmd_rd),
        .full  (full),
        .head  (head)
    );

    // Emit bytes
    rvp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .rd_en       (cmd_rd),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .packet_first(packet_first),
        .packet_last (packet_last),
        .frame_last  (frame_last)
    );

    // Frame end only on a packet end
    a_frame_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_last) |-> packet_last)
        else $error("frame_last without packet_last");

    // Packet end only on the last byte of a pixel
    a_packet_on_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && packet_last) |-> run_last)
        else $error("packet_last without run_last");

    // First header byte is never the last byte of a pixel
    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && packet_first) |-> !run_last)
        else $error("packet_first on run_last byte");

endmodule
